// ===== src/rps_pkg.sv =====
// Shared constants for the Rice parameter selector.
package rps_pkg;

   localparam int K_LOW_DEF        = 2;
   localparam int K_HIGH_DEF       = 14;
   localparam int LENGTH_WIDTH_DEF = 24;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int HEADER_BITS = 4;
   localparam int K_W         = 4;
   localparam int OUT_LEN_W   = 24;

endpackage

// ===== src/rps_front.sv =====
// Front stage: takes sample beats and maps each sample by zigzag.
module rps_front #(
   parameter int SAMPLE_BITS = rps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_last,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [SAMPLE_BITS-1:0] push_m,
   output logic                   push_last
);

   logic                   vld_ff, vld_in;
   logic [SAMPLE_BITS-1:0] m_ff;
   logic                   last_ff;
   logic [SAMPLE_BITS-1:0] zz;
   logic                   take;

   always_comb begin
      zz = {req_sample[SAMPLE_BITS-2:0], 1'b0} ^ {SAMPLE_BITS{req_sample[SAMPLE_BITS-1]}};
   end

   assign req_ready  = !vld_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = vld_ff;
   assign push_m     = m_ff;
   assign push_last  = last_ff;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         m_ff    <= zz;
         last_ff <= req_last;
      end
   end

endmodule

// ===== src/rps_queue.sv =====
// Two-entry queue between the front and back stages.
module rps_queue #(
   parameter int WIDTH = rps_pkg::SAMPLE_BITS_DEF + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] slot0_ff, slot1_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot0_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == 2'd2) begin
            slot0_ff <= slot1_ff;
         end else if (push) begin
            slot0_ff <= in_data;
         end
      end else if (push && count_ff == 2'd0) begin
         slot0_ff <= in_data;
      end
      if (push && !pop && count_ff == 2'd1) begin
         slot1_ff <= in_data;
      end
   end

endmodule

// ===== src/rps_back.sv =====
// Back stage: per-k length totals, registered minimum tree and result register.
module rps_back #(
   parameter int K_LOW        = rps_pkg::K_LOW_DEF,
   parameter int K_HIGH       = rps_pkg::K_HIGH_DEF,
   parameter int LENGTH_WIDTH = rps_pkg::LENGTH_WIDTH_DEF,
   parameter int SAMPLE_BITS  = rps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  logic [SAMPLE_BITS-1:0]         q_m,
   input  logic                           q_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rps_pkg::K_W-1:0]        rsp_best_k,
   output logic [rps_pkg::OUT_LEN_W-1:0]  rsp_best_length
);

   localparam int  KW     = rps_pkg::K_W;
   localparam int  OW     = rps_pkg::OUT_LEN_W;
   localparam bit  EMPTY  = (K_LOW > K_HIGH);
   localparam int  NUM_K  = EMPTY ? 1 : (K_HIGH - K_LOW + 1);
   localparam int  LEVELS = (NUM_K <= 2) ? 1 : $clog2(NUM_K);
   localparam int  P      = 1 << LEVELS;
   localparam int  NODES  = 2 * P - 1;
   localparam int  SUM_W  = ((LENGTH_WIDTH > SAMPLE_BITS + 1) ? LENGTH_WIDTH
                                                             : SAMPLE_BITS + 1) + 1;
   localparam logic [LENGTH_WIDTH-1:0] HDR     = LENGTH_WIDTH'(rps_pkg::HEADER_BITS);
   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

   logic                    adv;
   logic                    step;
   logic [LENGTH_WIDTH-1:0] acc_ff [NUM_K];
   logic [LENGTH_WIDTH-1:0] acc_in [NUM_K];
   logic [LENGTH_WIDTH-1:0] node_len_ff [NODES];
   logic [KW-1:0]           node_k_ff   [NODES];
   logic [LEVELS:0]         lvl_vld_ff;
   logic                    rsp_valid_ff;
   logic [KW-1:0]           rsp_k_ff;
   logic [OW-1:0]           rsp_len_ff;
   logic [OW-1:0]           clamp_len;

   assign adv     = !rsp_valid_ff || rsp_ready;
   assign q_ready = adv;
   assign step    = adv && q_valid;

   // per-k running totals, saturating
   for (genvar j = 0; j < NUM_K; j++) begin : g_acc
      logic [SUM_W-1:0] sum;
      always_comb begin
         sum = SUM_W'(acc_ff[j]) + SUM_W'(q_m >> (K_LOW + j)) + SUM_W'(K_LOW + j + 1);
         if (sum >= SUM_W'(LEN_MAX)) begin
            acc_in[j] = LEN_MAX;
         end else begin
            acc_in[j] = sum[LENGTH_WIDTH-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            acc_ff[j] <= HDR;
         end else if (step) begin
            acc_ff[j] <= q_last ? HDR : acc_in[j];
         end
      end
   end

   // leaves: snapshot of the totals on the last beat of a block
   for (genvar g = 0; g < P; g++) begin : g_leaf
      if (g < NUM_K) begin : g_real
         always_ff @(posedge clock) begin
            node_k_ff[P-1+g] <= KW'(K_LOW + g);
            if (step && q_last) begin
               node_len_ff[P-1+g] <= acc_in[g];
            end
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_k_ff[P-1+g]   <= KW'(K_LOW);
            node_len_ff[P-1+g] <= LEN_MAX;
         end
      end
   end

   // inner nodes: keep the left child on ties (smaller k)
   for (genvar n = 0; n < P - 1; n++) begin : g_node
      always_ff @(posedge clock) begin
         if (adv) begin
            if (node_len_ff[2*n+2] < node_len_ff[2*n+1]) begin
               node_len_ff[n] <= node_len_ff[2*n+2];
               node_k_ff[n]   <= node_k_ff[2*n+2];
            end else begin
               node_len_ff[n] <= node_len_ff[2*n+1];
               node_k_ff[n]   <= node_k_ff[2*n+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_vld_ff <= '0;
      end else if (adv) begin
         lvl_vld_ff <= {q_valid && q_last, lvl_vld_ff[LEVELS:1]};
      end
   end

   if (LENGTH_WIDTH > OW) begin : g_clamp
      assign clamp_len = (|node_len_ff[0][LENGTH_WIDTH-1:OW]) ? {OW{1'b1}}
                                                              : node_len_ff[0][OW-1:0];
   end else begin : g_ext
      assign clamp_len = OW'(node_len_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= lvl_vld_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (EMPTY) begin
            rsp_k_ff   <= KW'(K_LOW);
            rsp_len_ff <= OW'(rps_pkg::HEADER_BITS);
         end else begin
            rsp_k_ff   <= node_k_ff[0];
            rsp_len_ff <= clamp_len;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_k      = rsp_k_ff;
   assign rsp_best_length = rsp_len_ff;

endmodule

// ===== src/rice_parameter_selector.sv =====
// Top level of the Rice parameter selector.
//
//  channel  direction  payload                       handshake
//  req_     in         sample, last                  req_valid / req_ready
//  rsp_     out        best_k, best_length           rsp_valid / rsp_ready
//
// One sample beat per cycle is taken while req_ready is high. The beat with
// last passes the front register, the queue, the leaf registers, the L tree
// levels (ceil(log2) of the k count, 4 by default) and the result register.
// Reset sets every per-k total to the header length and empties all stages.
// A stall on rsp_ready holds the back stage; the two-entry queue and the
// front register then fill before req_ready drops.
module rice_parameter_selector #(
   parameter int K_LOW        = rps_pkg::K_LOW_DEF,
   parameter int K_HIGH       = rps_pkg::K_HIGH_DEF,
   parameter int LENGTH_WIDTH = rps_pkg::LENGTH_WIDTH_DEF,
   parameter int SAMPLE_BITS  = rps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [SAMPLE_BITS-1:0]        req_sample,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rps_pkg::K_W-1:0]       rsp_best_k,
   output logic [rps_pkg::OUT_LEN_W-1:0] rsp_best_length
);

   logic                   push_valid, push_ready;
   logic [SAMPLE_BITS-1:0] push_m;
   logic                   push_last;
   logic                   q_valid, q_ready;
   logic [SAMPLE_BITS:0]   q_data;

   rps_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_m     (push_m),
      .push_last  (push_last)
   );

   rps_queue #(
      .WIDTH (SAMPLE_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_m, push_last}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   rps_back #(
      .K_LOW        (K_LOW),
      .K_HIGH       (K_HIGH),
      .LENGTH_WIDTH (LENGTH_WIDTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_m             (q_data[SAMPLE_BITS:1]),
      .q_last          (q_data[0]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_best_k      (rsp_best_k),
      .rsp_best_length (rsp_best_length)
   );

endmodule

// ===== src/rps_checker.sv =====
// Port-level checks for the Rice parameter selector, bound to the top level.
module rps_checker #(
   parameter int K_LOW  = rps_pkg::K_LOW_DEF,
   parameter int K_HIGH = rps_pkg::K_HIGH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rps_pkg::K_W-1:0]       rsp_best_k,
   input logic [rps_pkg::OUT_LEN_W-1:0] rsp_best_length
);

   localparam int OW = rps_pkg::OUT_LEN_W;
   localparam logic [rps_pkg::K_W-1:0] KLO = rps_pkg::K_W'(K_LOW);
   localparam logic [rps_pkg::K_W-1:0] KHI = rps_pkg::K_W'(K_HIGH);
   localparam bit NON_EMPTY = (K_LOW <= K_HIGH);

   logic [4:0] pending_ff, pending_in;
   logic       in_last_beat, out_beat;

   assign in_last_beat = req_valid && req_ready && req_last;
   assign out_beat     = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + {4'd0, in_last_beat} - {4'd0, out_beat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_unasked_result: assert property (@(posedge clock) disable iff (reset)
      out_beat |-> pending_ff != 5'd0)
      else $error("result beat without a pending last sample");

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_k >= KLO && rsp_best_k <= KHI) || rsp_best_k == KLO)
      else $error("best_k outside the parameter range");

   a_length_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && NON_EMPTY |->
         rsp_best_length >= OW'(rps_pkg::HEADER_BITS + 1) + OW'(rsp_best_k))
      else $error("best_length below one coded sample plus header");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_best_k) && $stable(rsp_best_length))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind rice_parameter_selector rps_checker #(
   .K_LOW  (K_LOW),
   .K_HIGH (K_HIGH)
) u_rps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last        (req_last),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_best_k      (rsp_best_k),
   .rsp_best_length (rsp_best_length)
);
